// ----- src/imbe_pkg.sv -----
// Shared types and constants for the I2C master bit engine.
package imbe_pkg;

    localparam logic [2:0] REQ_START   = 3'd0;
    localparam logic [2:0] REQ_STOP    = 3'd1;
    localparam logic [2:0] REQ_WRITE   = 3'd2;
    localparam logic [2:0] REQ_READ    = 3'd3;
    localparam logic [2:0] REQ_RECOVER = 3'd4;

    localparam logic [0:0] REG_HALF_PERIOD = 1'b0;
    localparam logic [0:0] REG_RECOVER     = 1'b1;

    localparam logic [15:0] HALF_PERIOD_RST = 16'd125;
    localparam logic [3:0]  RECOVER_RST     = 4'd10;
    localparam logic [3:0]  BYTE_BITS       = 4'd8;

    typedef struct packed {
        logic       cmd_valid;
        logic [2:0] req_type;
        logic [7:0] wr_byte;
        logic       ack_on_read;
        logic       scl_in;
        logic       sda_in;
    } in_item_t;

    typedef struct packed {
        logic       scl_drive_low;
        logic       sda_drive_low;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rd_byte;
        logic       ack_seen;
        logic       recover_ok;
    } out_item_t;

    typedef struct packed {
        logic [15:0] half_period_ticks;
        logic [3:0]  recover_pulses;
    } cfg_t;

endpackage

// ----- src/imbe_regs.sv -----
// APB configuration registers of the I2C master bit engine.
module imbe_regs (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output imbe_pkg::cfg_t     cfg
);
    import imbe_pkg::*;

    logic [15:0] half_period_reg;
    logic [3:0]  recover_pulses_reg;
    logic        wr_en;

    assign wr_en = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            half_period_reg    <= HALF_PERIOD_RST;
            recover_pulses_reg <= RECOVER_RST;
        end else if (wr_en) begin
            case (paddr[2])
                REG_HALF_PERIOD: half_period_reg    <= pwdata[15:0];
                REG_RECOVER:     recover_pulses_reg <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_HALF_PERIOD: prdata = {16'd0, half_period_reg};
            REG_RECOVER:     prdata = {28'd0, recover_pulses_reg};
            default:         prdata = '0;
        endcase
    end

    assign cfg.half_period_ticks = half_period_reg;
    assign cfg.recover_pulses    = recover_pulses_reg;

endmodule

// ----- src/imbe_core.sv -----
// Bus sequencer of the I2C master bit engine: one tick per step, result registered.
module imbe_core #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                step_en,
    input  imbe_pkg::in_item_t  in_item,
    input  imbe_pkg::cfg_t      cfg,
    output imbe_pkg::out_item_t result
);
    import imbe_pkg::*;

    localparam int CW = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;
    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

    typedef enum logic [4:0] {
        PH_IDLE, PH_ST1, PH_ST2, PH_SP1, PH_SP2, PH_SP3,
        PH_WR_HI, PH_WR_LO, PH_WA_HI, PH_WA_SMP,
        PH_RD_HI, PH_RD_SMP, PH_RA_HI, PH_RA_LO,
        PH_RC_CHK, PH_RC_HI, PH_RC_LO, PH_RC_SP1, PH_RC_SP2, PH_RC_SP3
    } phase_t;

    phase_t                 phase_reg, phase_next;
    logic [3:0]             bit_count_reg, bit_count_next;
    logic [7:0]             shift_reg, shift_next;
    logic                   ack_flag_reg, ack_flag_next;
    logic [COUNT_WIDTH-1:0] tick_count_reg, tick_count_next;
    logic                   scl_rel_reg, scl_rel_next;
    logic                   sda_rel_reg, sda_rel_next;
    logic [3:0]             pulse_count_reg, pulse_count_next;
    logic                   recover_flag_reg, recover_flag_next;
    logic [7:0]             rd_latch_reg, rd_latch_next;
    logic                   ack_latch_reg, ack_latch_next;
    out_item_t              result_reg, result_next;

    logic [COUNT_WIDTH-1:0] tick_inc;
    logic [3:0]             bit_inc;
    logic [3:0]             pulse_inc;
    logic [7:0]             shift_left;
    logic                   fire;
    logic                   done;

    always_comb begin
        phase_next        = phase_reg;
        bit_count_next    = bit_count_reg;
        shift_next        = shift_reg;
        ack_flag_next     = ack_flag_reg;
        tick_count_next   = tick_count_reg;
        scl_rel_next      = scl_rel_reg;
        sda_rel_next      = sda_rel_reg;
        pulse_count_next  = pulse_count_reg;
        recover_flag_next = recover_flag_reg;
        rd_latch_next     = rd_latch_reg;
        ack_latch_next    = ack_latch_reg;
        done              = 1'b0;

        tick_inc   = (tick_count_reg != CNT_MAX) ? tick_count_reg + 1'b1 : tick_count_reg;
        fire       = (CW'(tick_inc) >= CW'(cfg.half_period_ticks)) || (tick_inc == CNT_MAX);
        bit_inc    = bit_count_reg + 4'd1;
        pulse_inc  = pulse_count_reg + 4'd1;
        shift_left = {shift_reg[6:0], 1'b0};

        if (phase_reg == PH_IDLE) begin
            if (in_item.cmd_valid) begin
                tick_count_next = '0;
                case (in_item.req_type)
                    REQ_START: begin
                        scl_rel_next = 1'b1;
                        sda_rel_next = 1'b1;
                        phase_next   = PH_ST1;
                    end
                    REQ_STOP: begin
                        sda_rel_next = 1'b0;
                        phase_next   = PH_SP1;
                    end
                    REQ_WRITE: begin
                        shift_next     = in_item.wr_byte;
                        ack_flag_next  = 1'b0;
                        bit_count_next = '0;
                        sda_rel_next   = in_item.wr_byte[7];
                        phase_next     = PH_WR_HI;
                    end
                    REQ_READ: begin
                        shift_next     = '0;
                        ack_flag_next  = in_item.ack_on_read;
                        bit_count_next = '0;
                        sda_rel_next   = 1'b1;
                        phase_next     = PH_RD_HI;
                    end
                    REQ_RECOVER: begin
                        scl_rel_next     = 1'b1;
                        sda_rel_next     = 1'b1;
                        pulse_count_next = '0;
                        phase_next       = PH_RC_CHK;
                    end
                    default: ;
                endcase
            end
        end else begin
            tick_count_next = tick_inc;
            if (fire) begin
                tick_count_next = '0;
                case (phase_reg)
                    PH_ST1: begin
                        sda_rel_next = 1'b0;
                        phase_next   = PH_ST2;
                    end
                    PH_ST2: begin
                        scl_rel_next = 1'b0;
                        phase_next   = PH_IDLE;
                        done         = 1'b1;
                    end
                    PH_SP1: begin
                        scl_rel_next = 1'b1;
                        phase_next   = PH_SP2;
                    end
                    PH_SP2: begin
                        sda_rel_next = 1'b1;
                        phase_next   = PH_SP3;
                    end
                    PH_SP3: begin
                        phase_next = PH_IDLE;
                        done       = 1'b1;
                    end
                    PH_WR_HI: begin
                        scl_rel_next = 1'b1;
                        phase_next   = PH_WR_LO;
                    end
                    PH_WR_LO: begin
                        scl_rel_next   = 1'b0;
                        shift_next     = shift_left;
                        bit_count_next = bit_inc;
                        if (bit_inc < BYTE_BITS) begin
                            sda_rel_next = shift_left[7];
                            phase_next   = PH_WR_HI;
                        end else begin
                            sda_rel_next = 1'b1;
                            phase_next   = PH_WA_HI;
                        end
                    end
                    PH_WA_HI: begin
                        scl_rel_next = 1'b1;
                        phase_next   = PH_WA_SMP;
                    end
                    PH_WA_SMP: begin
                        ack_flag_next  = !in_item.sda_in;
                        ack_latch_next = !in_item.sda_in;
                        scl_rel_next   = 1'b0;
                        phase_next     = PH_IDLE;
                        done           = 1'b1;
                    end
                    PH_RD_HI: begin
                        scl_rel_next = 1'b1;
                        phase_next   = PH_RD_SMP;
                    end
                    PH_RD_SMP: begin
                        shift_next     = {shift_reg[6:0], in_item.sda_in};
                        scl_rel_next   = 1'b0;
                        bit_count_next = bit_inc;
                        if (bit_inc < BYTE_BITS) begin
                            phase_next = PH_RD_HI;
                        end else begin
                            sda_rel_next = !ack_flag_reg;
                            phase_next   = PH_RA_HI;
                        end
                    end
                    PH_RA_HI: begin
                        scl_rel_next = 1'b1;
                        phase_next   = PH_RA_LO;
                    end
                    PH_RA_LO: begin
                        scl_rel_next  = 1'b0;
                        rd_latch_next = shift_reg;
                        phase_next    = PH_IDLE;
                        done          = 1'b1;
                    end
                    PH_RC_CHK: begin
                        if (!in_item.scl_in) begin
                            recover_flag_next = 1'b0;
                            phase_next        = PH_IDLE;
                            done              = 1'b1;
                        end else if (in_item.sda_in) begin
                            recover_flag_next = 1'b1;
                            phase_next        = PH_IDLE;
                            done              = 1'b1;
                        end else begin
                            scl_rel_next = 1'b0;
                            phase_next   = PH_RC_HI;
                        end
                    end
                    PH_RC_HI: begin
                        scl_rel_next = 1'b1;
                        phase_next   = PH_RC_LO;
                    end
                    PH_RC_LO: begin
                        pulse_count_next = pulse_inc;
                        if (pulse_inc < cfg.recover_pulses) begin
                            scl_rel_next = 1'b0;
                            phase_next   = PH_RC_HI;
                        end else begin
                            sda_rel_next = 1'b0;
                            phase_next   = PH_RC_SP1;
                        end
                    end
                    PH_RC_SP1: begin
                        scl_rel_next = 1'b1;
                        phase_next   = PH_RC_SP2;
                    end
                    PH_RC_SP2: begin
                        sda_rel_next = 1'b1;
                        phase_next   = PH_RC_SP3;
                    end
                    PH_RC_SP3: begin
                        recover_flag_next = in_item.scl_in && in_item.sda_in;
                        phase_next        = PH_IDLE;
                        done              = 1'b1;
                    end
                    default: begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end
        end

        result_next.scl_drive_low = !scl_rel_next;
        result_next.sda_drive_low = !sda_rel_next;
        result_next.busy_res      = (phase_next != PH_IDLE);
        result_next.done_res      = done;
        result_next.rd_byte       = rd_latch_next;
        result_next.ack_seen      = ack_latch_next;
        result_next.recover_ok    = recover_flag_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= PH_IDLE;
            bit_count_reg    <= '0;
            shift_reg        <= '0;
            ack_flag_reg     <= 1'b0;
            tick_count_reg   <= '0;
            scl_rel_reg      <= 1'b1;
            sda_rel_reg      <= 1'b1;
            pulse_count_reg  <= '0;
            recover_flag_reg <= 1'b0;
            rd_latch_reg     <= '0;
            ack_latch_reg    <= 1'b0;
        end else if (step_en) begin
            phase_reg        <= phase_next;
            bit_count_reg    <= bit_count_next;
            shift_reg        <= shift_next;
            ack_flag_reg     <= ack_flag_next;
            tick_count_reg   <= tick_count_next;
            scl_rel_reg      <= scl_rel_next;
            sda_rel_reg      <= sda_rel_next;
            pulse_count_reg  <= pulse_count_next;
            recover_flag_reg <= recover_flag_next;
            rd_latch_reg     <= rd_latch_next;
            ack_latch_reg    <= ack_latch_next;
        end
        if (step_en) begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule

// ----- src/i2c_master_bit_engine.sv -----
// Top level of the I2C master bit engine: request register, sequencer and APB registers.
// A request waits in the request register; the sequencer registers its result.
// Throughput: one request per cycle unless m_ready stalls; a sequencer tick per request.
// Reset: synchronous active-low aresetn idles the sequencer, releases its lines, clears
// its result latches (not m_payload) and loads 125 ticks and 10 recovery pulses.
module i2c_master_bit_engine #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    input  logic                s_valid,
    output logic                s_ready,
    input  imbe_pkg::in_item_t  s_payload,
    output logic                m_valid,
    input  logic                m_ready,
    output imbe_pkg::out_item_t m_payload
);
    import imbe_pkg::*;

    in_item_t in_item_reg;
    logic     in_valid_reg, in_valid_next;
    logic     out_valid_reg, out_valid_next;
    logic     advance;
    cfg_t     cfg;

    assign pready  = 1'b1;
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
        if (s_valid && s_ready) begin
            in_item_reg <= s_payload;
        end
    end

    imbe_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    imbe_core #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (advance),
        .in_item (in_item_reg),
        .cfg     (cfg),
        .result  (m_payload)
    );

    assign m_valid = out_valid_reg;

endmodule
